[src/omvl_pkg.sv]
// Package with the shared types and constants of the overcurrent majority vote latch.
`timescale 1ns / 1ps
`default_nettype none
package omvl_pkg;

    localparam int unsigned OMVL_WINDOW = 10;
    localparam int unsigned THR_W = 4;
    localparam int unsigned CNT_OUT_W = 4;
    localparam logic [THR_W-1:0] THR_RESET = 4'd7;

    typedef enum logic {
        ACT_TICK  = 1'b0,
        ACT_REARM = 1'b1
    } t_action;

    typedef struct packed {
        logic shift;
        logic load;
        logic load_val;
    } t_cell_ctrl;

endpackage
`default_nettype wire

[src/omvl_in_if.sv]
// Input item channel: action and fault line level.
`timescale 1ns / 1ps
`default_nettype none
interface omvl_in_if;
    import omvl_pkg::*;

    logic    valid;
    logic    ready;
    t_action action;
    logic    line_active;

    modport source (output valid, output action, output line_active, input ready);
    modport sink (input valid, input action, input line_active, output ready);
endinterface
`default_nettype wire

[src/omvl_out_if.sv]
// Result item channel: latch, count and fill status.
`timescale 1ns / 1ps
`default_nettype none
interface omvl_out_if;
    import omvl_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 fault_latched;
    logic [CNT_OUT_W-1:0] active_count;
    logic                 window_filled;

    modport source (output valid, output fault_latched, output active_count,
                    output window_filled, input ready);
    modport sink (input valid, input fault_latched, input active_count,
                  input window_filled, output ready);
endinterface
`default_nettype wire

[src/omvl_cfg_if.sv]
// Configuration write channel carrying the trip threshold.
`timescale 1ns / 1ps
`default_nettype none
interface omvl_cfg_if;
    import omvl_pkg::*;

    logic             valid;
    logic             ready;
    logic [THR_W-1:0] trip_threshold;

    modport source (output valid, output trip_threshold, input ready);
    modport sink (input valid, input trip_threshold, output ready);
endinterface
`default_nettype wire

[src/omvl_cell.sv]
// One sample cell of the window shift chain.
`timescale 1ns / 1ps
`default_nettype none
module omvl_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire omvl_pkg::t_cell_ctrl i_ctrl,
    input  wire logic                i_d,
    output logic                     o_q
);
    import omvl_pkg::*;

    logic r_q;
    logic n_q;

    always_comb begin
        n_q = r_q;
        if (i_ctrl.load) begin
            n_q = i_ctrl.load_val;
        end else if (i_ctrl.shift) begin
            n_q = i_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= 1'b0;
        end else begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule
`default_nettype wire

[src/overcurrent_majority_vote_latch_unit.sv]
// Top level of the overcurrent majority vote latch: cell chain, counters and result register.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+------------------------------------------
//   i_in     | in  | valid / ready | action, line_active
//   o_out    | out | valid / ready | fault_latched, active_count, window_filled
//   i_cfg    | in  | valid / ready | trip_threshold
//
// An item is taken every cycle while ready; its result is registered into the output register.
// The input is ready whenever the output register is empty or being read in the same cycle.
// The window is a chain of WINDOW cells that shifts once per tick; the oldest sample drops out.
// Reset clears the window, counters and latch and loads a trip threshold of seven.
// The configuration channel is always ready.
`timescale 1ns / 1ps
`default_nettype none
module overcurrent_majority_vote_latch_unit #(
    parameter int unsigned WINDOW = omvl_pkg::OMVL_WINDOW
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    omvl_in_if.sink     i_in,
    omvl_out_if.source  o_out,
    omvl_cfg_if.sink    i_cfg
);
    import omvl_pkg::*;

    localparam int unsigned CNT_W = $clog2(WINDOW + 1);
    localparam int unsigned CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(WINDOW);

    logic [THR_W-1:0] r_thr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic             r_fault, n_fault;
    logic             r_o_valid;
    logic             r_o_fault;
    logic [CNT_OUT_W-1:0] r_o_count;
    logic             r_o_filled;

    logic             in_acc;
    logic             is_rearm;
    t_cell_ctrl       cell_ctrl;
    logic [WINDOW-1:0] cell_q;
    logic             oldest;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_o_valid || o_out.ready;
    assign in_acc      = i_in.valid && i_in.ready;
    assign is_rearm    = (i_in.action == ACT_REARM);

    assign cell_ctrl.shift    = in_acc && !is_rearm;
    assign cell_ctrl.load     = in_acc && is_rearm;
    assign cell_ctrl.load_val = i_in.line_active;

    genvar g;
    generate
        for (g = 0; g < WINDOW; g++) begin : g_cell
            omvl_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (cell_ctrl),
                .i_d     ((g == 0) ? i_in.line_active : cell_q[(g == 0) ? 0 : g - 1]),
                .o_q     (cell_q[g])
            );
        end
    endgenerate

    assign oldest = cell_q[WINDOW-1];

    always_comb begin
        n_count = r_count;
        n_fill  = r_fill;
        n_fault = r_fault;
        if (is_rearm) begin
            if (i_in.line_active) begin
                n_count = FULL;
                n_fill  = FULL;
                n_fault = 1'b1;
            end else begin
                n_count = '0;
                n_fill  = '0;
                n_fault = 1'b0;
            end
        end else begin
            n_count = r_count - CNT_W'(oldest) + CNT_W'(i_in.line_active);
            if (r_fill != FULL) begin
                n_fill = r_fill + CNT_W'(1);
            end
            if ((n_fill == FULL) && (CMP_W'(n_count) >= CMP_W'(r_thr))) begin
                n_fault = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= THR_RESET;
            r_count   <= '0;
            r_fill    <= '0;
            r_fault   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_thr <= i_cfg.trip_threshold;
            end
            if (in_acc) begin
                r_count   <= n_count;
                r_fill    <= n_fill;
                r_fault   <= n_fault;
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_o_fault  <= n_fault;
            r_o_count  <= CNT_OUT_W'(n_count);
            r_o_filled <= (n_fill == FULL);
        end
    end

    assign o_out.valid         = r_o_valid;
    assign o_out.fault_latched = r_o_fault;
    assign o_out.active_count  = r_o_count;
    assign o_out.window_filled = r_o_filled;
endmodule
`default_nettype wire

[src/omvl_checker.sv]
// Port-level checker for the overcurrent majority vote latch and its bind.
`timescale 1ns / 1ps
`default_nettype none
module omvl_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_in_action,
    input wire logic       i_in_line_active,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic       i_out_fault,
    input wire logic [3:0] i_out_count,
    input wire logic       i_out_filled
);
    import omvl_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    a_rearm_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_action == ACT_REARM) && !i_in_line_active |=>
        i_out_valid && !i_out_fault && (i_out_count == 4'd0) && !i_out_filled)
        else $error("rearm with inactive line did not clear the filter");

    a_rearm_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_action == ACT_REARM) && i_in_line_active |=>
        i_out_valid && i_out_fault && i_out_filled)
        else $error("rearm with active line did not set the latch");

    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_action == ACT_TICK) && i_out_valid && i_out_fault |=>
        i_out_fault)
        else $error("fault latch released by a tick");

    a_fault_needs_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_fault |-> i_out_filled)
        else $error("fault latched before the window filled");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_fault) &&
        $stable(i_out_count) && $stable(i_out_filled))
        else $error("stalled result item changed");
endmodule

bind overcurrent_majority_vote_latch_unit omvl_checker u_omvl_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_in_action      (i_in.action),
    .i_in_line_active (i_in.line_active),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_fault      (o_out.fault_latched),
    .i_out_count      (o_out.active_count),
    .i_out_filled     (o_out.window_filled)
);
`default_nettype wire

[dv/testbench.sv]
// Testbench for the overcurrent majority vote latch: predicts every result item and checks it.
`timescale 1ns / 1ps
module testbench;
    import omvl_pkg::*;

    localparam int unsigned N_PHASES        = 10;
    localparam int unsigned ITEMS_PER_PHASE = 50;
    localparam int unsigned HOLD_CYCLES     = 60;
    localparam int unsigned WATCHDOG_LIMIT  = 1000;
    localparam int unsigned PRINT_LIMIT     = 40;

    typedef struct packed {
        logic                 fault_latched;
        logic [CNT_OUT_W-1:0] active_count;
        logic                 window_filled;
    } t_latch_result;

    class latch_scoreboard;
        bit               window_bits[OMVL_WINDOW];
        int unsigned      slot;
        int unsigned      active_total;
        int unsigned      taken;
        bit               fault;
        logic [THR_W-1:0] threshold;
        t_latch_result    expected_q[$];
        int unsigned      errors;
        int unsigned      checked;

        function new();
            fill_window(1'b0);
            fault     = 1'b0;
            threshold = THR_RESET;
            errors    = 0;
            checked   = 0;
        endfunction

        function void fill_window(bit lvl);
            foreach (window_bits[k]) window_bits[k] = lvl;
            slot         = 0;
            active_total = lvl ? OMVL_WINDOW : 0;
            taken        = lvl ? OMVL_WINDOW : 0;
        endfunction

        function void set_threshold(logic [THR_W-1:0] thr);
            threshold = thr;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_input(t_action act, logic lvl);
            t_latch_result res;
            if (act == ACT_REARM) begin
                fill_window(lvl);
                fault = lvl;
            end else begin
                if (window_bits[slot] && active_total > 0) active_total--;
                window_bits[slot] = lvl;
                if (lvl && active_total < OMVL_WINDOW) active_total++;
                slot = (slot + 1 == OMVL_WINDOW) ? 0 : slot + 1;
                if (taken < OMVL_WINDOW) taken++;
                if (taken >= OMVL_WINDOW && active_total >= threshold) fault = 1'b1;
            end
            res.fault_latched = fault;
            res.active_count  = CNT_OUT_W'(active_total);
            res.window_filled = (taken >= OMVL_WINDOW);
            expected_q.push_back(res);
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_latch_result got);
            t_latch_result want;
            if (expected_q.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected", checked));
            end else begin
                want = expected_q.pop_front();
                if (got.fault_latched !== want.fault_latched)
                    report($sformatf("result %0d: fault_latched %b, expected %b",
                                     checked, got.fault_latched, want.fault_latched));
                if (got.active_count !== want.active_count)
                    report($sformatf("result %0d: active_count %0d, expected %0d",
                                     checked, got.active_count, want.active_count));
                if (got.window_filled !== want.window_filled)
                    report($sformatf("result %0d: window_filled %b, expected %b",
                                     checked, got.window_filled, want.window_filled));
            end
            checked++;
        endtask
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    omvl_in_if  in_ch();
    omvl_out_if out_ch();
    omvl_cfg_if cfg_ch();

    overcurrent_majority_vote_latch_unit i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    latch_scoreboard sb;
    bit              gaps_on   = 1'b0;
    bit              stalls_on = 1'b0;
    bit              hold_req  = 1'b0;
    int unsigned     idle_cycles;
    int unsigned     n_items;
    int unsigned     n_rearms;
    int unsigned     n_latched;
    int unsigned     n_cfg;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic [THR_W-1:0] THR_WIDTH_RAND();
        return THR_W'($urandom_range(0, (1 << THR_W) - 1));
    endfunction

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                sb.check_result({out_ch.fault_latched, out_ch.active_count,
                                 out_ch.window_filled});
                if (out_ch.fault_latched === 1'b1) n_latched++;
            end
            if (in_ch.valid && in_ch.ready) begin
                sb.note_input(in_ch.action, in_ch.line_active);
                n_items++;
                if (in_ch.action == ACT_REARM) n_rearms++;
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("Watchdog: no item moved for %0d cycles.", idle_cycles);
                    $display("CHECKS FAILED");
                    $finish;
                end
            end
        end
    end

    initial begin : result_side
        int unsigned stall;
        out_ch.ready <= 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
                hold_req = 1'b0;
            end else if (stalls_on && $urandom_range(0, 3) == 0) begin
                stall = pick_gap() + 1;
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic send_item(t_action act, logic lvl);
        int unsigned gap;
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.line_active <= lvl;
        do @(posedge clk); while (!in_ch.ready);
        gap = gaps_on ? pick_gap() : 0;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] thr);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.trip_threshold <= thr;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.set_threshold(thr);
        n_cfg++;
    endtask

    initial begin : stimulus
        int unsigned      pct_choice[4];
        int unsigned      one_pct;
        logic [THR_W-1:0] thr;
        pct_choice = '{10, 50, 90, 100};
        sb = new();
        in_ch.valid           <= 1'b0;
        in_ch.action          <= ACT_TICK;
        in_ch.line_active     <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.trip_threshold <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With the reset threshold the count passes it before the window has filled.
        for (int k = 0; k < 9; k++) send_item(ACT_TICK, 1'b1);
        send_item(ACT_TICK, 1'b0);
        send_item(ACT_TICK, 1'b1);
        send_item(ACT_REARM, 1'b0);
        send_item(ACT_REARM, 1'b1);
        send_item(ACT_TICK, 1'b0);
        send_item(ACT_TICK, 1'b1);
        send_item(ACT_REARM, 1'b1);
        send_item(ACT_REARM, 1'b0);
        send_item(ACT_TICK, 1'b0);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0:       thr = 4'd0;
                1:       thr = 4'd1;
                2:       thr = 4'd10;
                3:       thr = 4'd11;
                4:       thr = 4'd15;
                5:       thr = THR_RESET;
                default: thr = THR_WIDTH_RAND();
            endcase
            write_threshold(thr);
            gaps_on   = ($urandom_range(0, 2) != 0);
            stalls_on = ($urandom_range(0, 2) != 0);
            if (ph == 3) begin
                gaps_on  = 1'b0;
                hold_req = 1'b1;
            end
            send_item(ACT_REARM, 1'b0);
            one_pct = pct_choice[$urandom_range(0, 3)];
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k % 12 == 11) one_pct = pct_choice[$urandom_range(0, 3)];
                if ($urandom_range(0, 99) < 5)
                    send_item(ACT_REARM, $urandom_range(0, 99) < 40);
                else
                    send_item(ACT_TICK, $urandom_range(0, 99) < one_pct);
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        $display("Run covered %0d items, %0d of them rearms, under %0d threshold settings.",
                 n_items, n_rearms, n_cfg);
        $display("Checked %0d results, %0d with the fault latched; %0d mismatches.",
                 sb.checked, n_latched, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            if (sb.pending() != 0) $display("%0d expected results never arrived.", sb.pending());
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
